// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define TSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/tsd_pkg.sv =====
// Package for the touch swipe detector: sizes, codes, slot entry type.
// No dependencies.
`default_nettype none

package tsd_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;

    localparam logic [15:0] WINDOW_WIDTH_RST  = 16'd1920;
    localparam logic [15:0] WINDOW_HEIGHT_RST = 16'd1080;

    localparam logic [1:0] FUNC_DOWN   = 2'd0;
    localparam logic [1:0] FUNC_UP     = 2'd1;
    localparam logic [1:0] FUNC_MOTION = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [7:0]  device;
        logic [15:0] finger;
        logic [15:0] x;
        logic [15:0] y;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } free_slot_t;

    // Lowest-numbered free slot.
    function automatic free_slot_t find_free(input logic [SLOTS-1:0] busy);
        free_slot_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                res.found = 1'b1;
                res.idx   = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsd_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tsd_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/touch_swipe_detector.sv =====
// Touch swipe detector top level: slot table control, displacement test, ports.
// Depends on tsd_pkg and tsd_ram.
`default_nettype none

// One request at a time. A finger-down or motion request goes straight to the
// done state, and its result is registered into the output once the output
// register is free; the next request can then be taken. A finger-up request
// scans the slot memory through its single read port, a read and a compare
// state per slot checked, stopping at the first busy slot with the same device
// and finger; a match goes on through multiply and decide states. The slot busy
// bits clear at reset; there is no clearing pass. A finished result waits in the
// output register while the next request is accepted. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
module touch_swipe_detector import tsd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_func,
    input  wire logic [7:0]           s_touch_device,
    input  wire logic [15:0]          s_finger,
    input  wire logic [15:0]          s_x_pos,
    input  wire logic [15:0]          s_y_pos,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_swipe_valid,
    output logic [1:0]                m_direction,
    output logic                      m_error_flag,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOTS-1:0]  busy_reg, busy_next;
    logic [15:0]       width_reg, height_reg;
    logic              m_valid_reg;

    logic [7:0]  dev_reg;
    logic [15:0] finger_reg, x_reg, y_reg;
    logic [15:0] mag_x_reg, mag_y_reg;
    logic        neg_x_reg, neg_y_reg;
    logic [31:0] prod_x_reg, prod_y_reg;
    logic [15:0] lim_reg;
    logic        res_swipe_reg, res_err_reg;
    logic [1:0]  res_dir_reg;
    logic        m_swipe_reg, m_err_reg;
    logic [1:0]  m_dir_reg;

    logic              accept;
    free_slot_t        free_slot;
    logic              ram_we;
    slot_entry_t       wr_entry, rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic              hit;
    logic [16:0]       dx, dy, mag_x, mag_y;
    logic [34:0]       scaled_x, scaled_y, limit_ext;
    logic              beyond_x, beyond_y;
    logic              out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign free_slot = find_free(busy_reg);
    assign out_free  = !m_valid_reg || m_ready;

    assign ram_we   = accept && (s_func == FUNC_DOWN) && free_slot.found;
    assign wr_entry = '{device: s_touch_device, finger: s_finger, x: s_x_pos, y: s_y_pos};

    tsd_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (free_slot.idx),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_raw)
    );

    assign rd_entry = slot_entry_t'(rd_raw);
    assign hit = busy_reg[idx_reg] && (rd_entry.device == dev_reg)
                 && (rd_entry.finger == finger_reg);

    assign dx    = {1'b0, x_reg} - {1'b0, rd_entry.x};
    assign dy    = {1'b0, y_reg} - {1'b0, rd_entry.y};
    assign mag_x = dx[16] ? (17'd0 - dx) : dx;
    assign mag_y = dy[16] ? (17'd0 - dy) : dy;

    // |d| * scale * 5 > min_side * 65536
    assign scaled_x  = {1'b0, prod_x_reg, 2'b00} + {3'b000, prod_x_reg};
    assign scaled_y  = {1'b0, prod_y_reg, 2'b00} + {3'b000, prod_y_reg};
    assign limit_ext = {3'b000, lim_reg, 16'h0000};
    assign beyond_x  = scaled_x > limit_ext;
    assign beyond_y  = scaled_y > limit_ext;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_UP) begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end else begin
                        if ((s_func == FUNC_DOWN) && free_slot.found) begin
                            busy_next[free_slot.idx] = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (hit) begin
                    busy_next[idx_reg] = 1'b0;
                    state_next = ST_MUL;
                end else if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_MUL: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            busy_reg    <= '0;
            width_reg   <= WINDOW_WIDTH_RST;
            height_reg  <= WINDOW_HEIGHT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WINDOW_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == REG_WINDOW_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dev_reg       <= s_touch_device;
            finger_reg    <= s_finger;
            x_reg         <= s_x_pos;
            y_reg         <= s_y_pos;
            res_swipe_reg <= 1'b0;
            res_dir_reg   <= DIR_LEFT;
            res_err_reg   <= (s_func == FUNC_DOWN) && !free_slot.found;
        end
        if (state_reg == ST_CMP) begin
            mag_x_reg <= mag_x[15:0];
            mag_y_reg <= mag_y[15:0];
            neg_x_reg <= dx[16];
            neg_y_reg <= dy[16];
            if (!hit && (idx_reg == SLOT_W'(SLOTS - 1))) begin
                res_err_reg <= 1'b1;
            end
        end
        if (state_reg == ST_MUL) begin
            prod_x_reg <= 32'(mag_x_reg) * 32'(width_reg);
            prod_y_reg <= 32'(mag_y_reg) * 32'(height_reg);
            lim_reg    <= (width_reg < height_reg) ? width_reg : height_reg;
        end
        if (state_reg == ST_DECIDE) begin
            if (beyond_x) begin
                res_swipe_reg <= 1'b1;
                res_dir_reg   <= neg_x_reg ? DIR_LEFT : DIR_RIGHT;
            end else if (beyond_y) begin
                res_swipe_reg <= 1'b1;
                res_dir_reg   <= neg_y_reg ? DIR_UP : DIR_DOWN;
            end
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_swipe_reg <= res_swipe_reg;
            m_dir_reg   <= res_dir_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_swipe_valid = m_swipe_reg;
    assign m_direction   = m_dir_reg;
    assign m_error_flag  = m_err_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tsd_checker.sv =====
// Port-level checker for the touch swipe detector, bound to the top level.
// Depends on tsd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tsd_port_checker import tsd_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_swipe_valid,
    input wire logic [1:0] m_direction,
    input wire logic       m_error_flag
);

    logic       m_stall;
    logic       s_take;
    logic       m_swipe;
    logic       m_plain;
    logic [3:0] m_payload;

    assign m_stall   = m_valid && !m_ready;
    assign s_take    = s_valid && s_ready;
    assign m_swipe   = m_valid && m_swipe_valid;
    assign m_plain   = m_valid && !m_swipe_valid;
    assign m_payload = {m_swipe_valid, m_direction, m_error_flag};

    `TSD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_valid && $stable(m_payload))
    `TSD_ASSERT_IMPLY(a_swipe_no_err, aclk, aresetn, m_swipe, !m_error_flag)
    `TSD_ASSERT_IMPLY(a_no_swipe_dir, aclk, aresetn, m_plain, m_direction == DIR_LEFT)
    `TSD_ASSERT_NEXT(a_one_request, aclk, aresetn, s_take, !s_ready)

endmodule

bind touch_swipe_detector tsd_port_checker u_tsd_checker (.*);

`default_nettype wire
